[sv/sfla_pkg.sv]
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared types, codes and the size-class table for the free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int unsigned SIZE_W = 26;
  localparam int unsigned ADDR_W = 20;
  localparam int unsigned CLS_W  = 4;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned MAX_CLASSES = 16;

  // Class sizes in bytes; entry 0 is replaced by the minimum block size.
  localparam logic [SIZE_W-1:0] CLASS_BYTES [MAX_CLASSES] = '{
    26'd8,       26'd32,      26'd64,      26'd128,
    26'd512,     26'd1024,    26'd4096,    26'd16384,
    26'd32768,   26'd65536,   26'd131072,  26'd524288,
    26'd1048576, 26'd4194304, 26'd8388608, 26'd33554432
  };

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_MEM    = 3'd3,
    ST_BAD_FREE  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_POP,
    S_FREE
  } sfla_state_e;

  // Datapath conditions seen by the sequencer
  typedef struct packed {
    logic clear_last;
    logic is_free;
    logic req_err;
    logic count_nz;
    logic no_mem;
    logic addr_bad;
    logic out_free;
  } dp_stat_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic ready;
    logic clear_en;
    logic meta_rd;
    logic link_rd;
    logic sel_tag;
    logic done_err;
    logic done_bump;
    logic done_pop;
    logic done_free;
  } ctrl_t;

  function automatic logic [SIZE_W-1:0] class_size(input logic [CLS_W-1:0] k,
                                                   input logic [SIZE_W-1:0] first);
    logic [SIZE_W-1:0] r;
    r = (k == '0) ? first : CLASS_BYTES[k];
    return r;
  endfunction

endpackage

[sv/sfla_ram.sv]
// ----------------------------------------------------------------------------
// sfla_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sfla_ram #(
  parameter int unsigned DEPTH = 131072,
  parameter int unsigned WIDTH = 5
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[sv/sfla_class_map.sv]
// ----------------------------------------------------------------------------
// sfla_class_map
// Maps a request size to the smallest size class that holds it.
// ----------------------------------------------------------------------------
module sfla_class_map import sfla_pkg::*; #(
  parameter int unsigned NUM_CLASSES = 16,
  parameter int unsigned MIN_BLOCK   = 8
) (
  input  logic [SIZE_W-1:0] size_i,
  output logic [CLS_W-1:0]  cls_o,
  output logic [SIZE_W-1:0] bytes_o,
  output logic              zero_o,
  output logic              too_large_o
);

  localparam logic [SIZE_W-1:0] FIRST = SIZE_W'(MIN_BLOCK);

  logic found;

  // first class in table order whose size holds the request
  always_comb begin
    found   = 1'b0;
    cls_o   = '0;
    bytes_o = FIRST;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      if (!found && (class_size(CLS_W'(k), FIRST) >= size_i)) begin
        found   = 1'b1;
        cls_o   = CLS_W'(k);
        bytes_o = class_size(CLS_W'(k), FIRST);
      end
    end
  end

  assign zero_o      = (size_i == '0);
  assign too_large_o = (size_i > class_size(CLS_W'(NUM_CLASSES - 1), FIRST));

endmodule

[sv/sfla_fsm.sv]
// ----------------------------------------------------------------------------
// sfla_fsm
// Sequencer: clearing sweep, request decode, list pop and free push steps.
// ----------------------------------------------------------------------------
module sfla_fsm import sfla_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  dp_stat_t stat_i,
  input  logic     in_use_i,
  output ctrl_t    ctrl_o
);

  sfla_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (stat_i.is_free) begin
          if (!stat_i.addr_bad) begin
            state_d = S_FREE;
          end else if (stat_i.out_free) begin
            state_d = S_IDLE;
          end
        end else if (!stat_i.req_err && stat_i.count_nz) begin
          state_d = S_POP;
        end else if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_POP, S_FREE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      S_CLEAR: ctrl_o.clear_en = 1'b1;
      S_IDLE:  ctrl_o.ready    = 1'b1;
      S_DECODE: begin
        if (stat_i.is_free) begin
          if (stat_i.addr_bad) begin
            ctrl_o.done_err = stat_i.out_free;
          end else begin
            ctrl_o.meta_rd = 1'b1;
          end
        end else if (stat_i.req_err) begin
          ctrl_o.done_err = stat_i.out_free;
        end else if (stat_i.count_nz) begin
          ctrl_o.link_rd = 1'b1;
        end else if (stat_i.no_mem) begin
          ctrl_o.done_err = stat_i.out_free;
        end else begin
          ctrl_o.done_bump = stat_i.out_free;
        end
      end
      S_POP: ctrl_o.done_pop = stat_i.out_free;
      S_FREE: begin
        ctrl_o.sel_tag   = 1'b1;
        ctrl_o.done_free = stat_i.out_free;
        ctrl_o.done_err  = 1'b0;
        ctrl_o.link_rd   = 1'b0;
        ctrl_o.meta_rd   = 1'b0;
        ctrl_o.done_bump = 1'b0;
        ctrl_o.done_pop  = 1'b0;
        ctrl_o.clear_en  = 1'b0;
        ctrl_o.ready     = 1'b0 & in_use_i;
      end
      default: ctrl_o = '0;
    endcase
  end

endmodule

[sv/segregated_free_list_allocator_top.sv]
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_top
// After reset a sweep over all HEAP_BYTES/MIN_BLOCK granules clears the
// block tags; no transaction is taken meanwhile. Request errors, bad free
// addresses, out of memory and bump allocations register their result in
// DECODE; list pops and aligned in-heap frees in POP or FREE, after the
// synchronous read of the link or tag memory before the head update. The
// next request is taken in IDLE once the result is registered, one at a time.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_top import sfla_pkg::*; #(
  parameter int unsigned HEAP_BYTES  = 1048576, // power of two
  parameter int unsigned NUM_CLASSES = 16,
  parameter int unsigned MIN_BLOCK   = 8        // power of two
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // req_size[25:0], free_addr[45:26], zero pad
  input  logic        s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // granted_addr[19:0], size_class[23:20],
                                     // block_bytes[49:24], reused[50], zero pad
  output logic [2:0]  m_axis_tuser   // status
);

  localparam int unsigned GRANULES = HEAP_BYTES / MIN_BLOCK;
  localparam int unsigned IDX_W    = $clog2(GRANULES);
  localparam int unsigned CNT_W    = $clog2(GRANULES + 1);
  localparam int unsigned BP_W     = $clog2(HEAP_BYTES + 1);
  localparam int unsigned GRAN_SH  = $clog2(MIN_BLOCK);
  localparam int unsigned SUM_W    = ((BP_W > SIZE_W) ? BP_W : SIZE_W) + 1;
  localparam int unsigned META_W   = CLS_W + 1;
  localparam logic [SIZE_W-1:0] FIRST = SIZE_W'(MIN_BLOCK);

  ctrl_t    ctrl;
  dp_stat_t stat;

  // request registers
  logic              req_type_q;
  logic [ADDR_W-1:0] free_addr_q;
  logic [CLS_W-1:0]  cls_q;
  logic [SIZE_W-1:0] bytes_q;
  logic              zero_q, big_q;

  logic [CLS_W-1:0]  map_cls;
  logic [SIZE_W-1:0] map_bytes;
  logic              map_zero, map_big;

  // allocator state
  logic [BP_W-1:0]  bump_q;
  logic [IDX_W-1:0] clr_q;
  logic [IDX_W-1:0] head_q  [NUM_CLASSES];
  logic [CNT_W-1:0] count_q [NUM_CLASSES];

  // memories
  logic              meta_we;
  logic [IDX_W-1:0]  meta_waddr;
  logic [META_W-1:0] meta_wdata, meta_rdata;
  logic              link_we;
  logic [IDX_W-1:0]  link_rdata;

  logic [CLS_W-1:0]  tag, tag_cls, cls_sel;
  logic              in_use;
  logic [IDX_W-1:0]  head_sel, free_idx, bump_idx;
  logic [CNT_W-1:0]  cnt_sel;
  logic              acc, out_load;

  // output register
  logic              out_valid_q;
  status_e           out_status_q, out_status_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  logic [CLS_W-1:0]  out_cls_q, out_cls_d;
  logic [SIZE_W-1:0] out_bytes_q, out_bytes_d;
  logic              out_reused_q, out_reused_d;

  sfla_class_map #(
    .NUM_CLASSES (NUM_CLASSES),
    .MIN_BLOCK   (MIN_BLOCK)
  ) u_class_map (
    .size_i      (s_axis_tdata[25:0]),
    .cls_o       (map_cls),
    .bytes_o     (map_bytes),
    .zero_o      (map_zero),
    .too_large_o (map_big)
  );

  sfla_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .in_use_i   (in_use),
    .ctrl_o     (ctrl)
  );

  // in-use flag and class tag per granule
  sfla_ram #(
    .DEPTH (GRANULES),
    .WIDTH (META_W)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (ctrl.meta_rd),
    .raddr_i (free_idx),
    .rdata_o (meta_rdata)
  );

  // free-list links per granule
  sfla_ram #(
    .DEPTH (GRANULES),
    .WIDTH (IDX_W)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (free_idx),
    .wdata_i (head_sel),
    .re_i    (ctrl.link_rd),
    .raddr_i (head_sel),
    .rdata_o (link_rdata)
  );

  assign acc           = s_axis_tvalid & ctrl.ready;
  assign s_axis_tready = ctrl.ready;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      req_type_q  <= s_axis_tuser;
      free_addr_q <= s_axis_tdata[45:26];
      cls_q       <= map_cls;
      bytes_q     <= map_bytes;
      zero_q      <= map_zero;
      big_q       <= map_big;
    end
  end

  assign tag     = meta_rdata[CLS_W-1:0];
  assign in_use  = meta_rdata[CLS_W];
  assign tag_cls = ({1'b0, tag} >= (CLS_W + 1)'(NUM_CLASSES)) ?
                   CLS_W'(NUM_CLASSES - 1) : tag;
  assign cls_sel = ctrl.sel_tag ? tag_cls : cls_q;

  assign head_sel = head_q[cls_sel];
  assign cnt_sel  = count_q[cls_sel];
  assign free_idx = IDX_W'({{IDX_W{1'b0}}, free_addr_q} >> GRAN_SH);
  assign bump_idx = IDX_W'(bump_q >> GRAN_SH);

  assign stat.clear_last = (clr_q == IDX_W'(GRANULES - 1));
  assign stat.is_free    = req_type_q;
  assign stat.req_err    = zero_q | big_q;
  assign stat.count_nz   = (cnt_sel != '0);
  assign stat.no_mem     = (SUM_W'(bump_q) + SUM_W'(bytes_q)) > SUM_W'(HEAP_BYTES);
  assign stat.addr_bad   = (32'(free_addr_q) >= 32'(HEAP_BYTES)) |
                           (|free_addr_q[GRAN_SH-1:0]);
  assign stat.out_free   = !out_valid_q | m_axis_tready;

  // memory write port selection
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = free_idx;
    meta_wdata = '0;
    if (ctrl.clear_en) begin
      meta_we    = 1'b1;
      meta_waddr = clr_q;
    end else if (ctrl.done_bump) begin
      meta_we    = 1'b1;
      meta_waddr = bump_idx;
      meta_wdata = {1'b1, cls_q};
    end else if (ctrl.done_pop) begin
      meta_we    = 1'b1;
      meta_waddr = head_sel;
      meta_wdata = {1'b1, cls_q};
    end else if (ctrl.done_free && in_use) begin
      meta_we    = 1'b1;
    end
  end

  assign link_we = ctrl.done_free & in_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      bump_q <= '0;
    end else begin
      if (ctrl.clear_en) clr_q <= clr_q + 1'b1;
      if (ctrl.done_bump) bump_q <= bump_q + BP_W'(bytes_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CLASSES; k++) count_q[k] <= '0;
    end else if (ctrl.done_pop) begin
      count_q[cls_sel] <= cnt_sel - 1'b1;
    end else if (link_we) begin
      count_q[cls_sel] <= cnt_sel + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.done_pop) begin
      head_q[cls_sel] <= link_rdata;
    end else if (link_we) begin
      head_q[cls_sel] <= free_idx;
    end
  end

  // result fields
  assign out_load = ctrl.done_err | ctrl.done_bump | ctrl.done_pop | ctrl.done_free;

  always_comb begin
    out_status_d = ST_OK;
    out_addr_d   = '0;
    out_cls_d    = '0;
    out_bytes_d  = '0;
    out_reused_d = 1'b0;
    if (ctrl.done_err) begin
      if (req_type_q) begin
        out_status_d = ST_BAD_FREE;
      end else if (zero_q) begin
        out_status_d = ST_ZERO;
      end else if (big_q) begin
        out_status_d = ST_TOO_LARGE;
      end else begin
        out_status_d = ST_NO_MEM;
        out_cls_d    = cls_q;
      end
    end else if (ctrl.done_bump) begin
      out_addr_d  = ADDR_W'(bump_q);
      out_cls_d   = cls_q;
      out_bytes_d = bytes_q;
    end else if (ctrl.done_pop) begin
      out_addr_d   = ADDR_W'({{ADDR_W{1'b0}}, head_sel} << GRAN_SH);
      out_cls_d    = cls_q;
      out_bytes_d  = bytes_q;
      out_reused_d = 1'b1;
    end else if (in_use) begin
      out_cls_d   = tag_cls;
      out_bytes_d = class_size(tag_cls, FIRST);
    end else begin
      out_status_d = ST_BAD_FREE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load | (out_valid_q & !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_addr_q   <= out_addr_d;
      out_cls_q    <= out_cls_d;
      out_bytes_q  <= out_bytes_d;
      out_reused_q <= out_reused_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {5'b0, out_reused_q, out_bytes_q, out_cls_q, out_addr_q};

  a_bump_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q <= BP_W'(HEAP_BYTES))
    else $error("bump pointer beyond heap");

  a_bump_fresh_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bump_q != $past(bump_q)) |-> $past(ctrl.done_bump))
    else $error("bump pointer moved without a fresh block");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear_en |-> !s_axis_tready)
    else $error("transaction accepted during clearing sweep");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.done_pop |-> (cnt_sel != '0))
    else $error("pop from an empty class list");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_status_q != ST_OK)) |->
      (out_addr_q == '0) && (out_bytes_q == '0) && !out_reused_q)
    else $error("error result carries block fields");

endmodule

[bench/tb_segregated_free_list_allocator_top.sv]
// ----------------------------------------------------------------------------
// tb_segregated_free_list_allocator_top
// Stream-level check of the free-list allocator. A directed opening covers
// zero and oversize requests, out of memory, bad and double frees, class
// boundaries and list reuse; a random phase follows, with burst/gap stimulus
// and a stalling receiver. Each result is compared with an in-bench allocator
// model updated on every accepted request.
// ----------------------------------------------------------------------------
module tb_segregated_free_list_allocator_top import sfla_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_BYTES  = 1048576;
  localparam int unsigned NUM_CLASSES = 16;
  localparam int unsigned MIN_BLOCK   = 8;
  localparam int unsigned GRANULES    = HEAP_BYTES / MIN_BLOCK;
  localparam int unsigned MAX_SIZE    = 67108863;

  localparam bit REQ_ALLOC = 1'b0;
  localparam bit REQ_FREE  = 1'b1;

  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned PAUSE_AT     = 700;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct {
    bit          is_free;
    logic [25:0] size;
    logic [19:0] addr;
  } request_t;

  typedef struct {
    status_e     status;
    logic [19:0] addr;
    logic [3:0]  cls;
    logic [25:0] bytes;
    logic        reused;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // req_size[25:0], free_addr[45:26], zero pad
  logic        s_axis_tuser = 1'b0; // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // granted_addr[19:0], size_class[23:20],
                                    // block_bytes[49:24], reused[50], zero pad
  logic [2:0]  m_axis_tuser;        // status

  segregated_free_list_allocator_top #(
    .HEAP_BYTES (HEAP_BYTES),
    .NUM_CLASSES(NUM_CLASSES),
    .MIN_BLOCK  (MIN_BLOCK)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Allocator model state
  longint unsigned bump_ptr = 0;
  int unsigned     list_head  [NUM_CLASSES];
  int unsigned     list_len   [NUM_CLASSES];
  int unsigned     link_of    [GRANULES];
  bit              block_live [GRANULES];
  bit [3:0]        block_tag  [GRANULES];
  int unsigned     live_blocks[$];
  int unsigned     freed_blocks[$];

  request_t    req_q[$];
  grant_t      grant_q[$];
  int unsigned items_pushed = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  bit          s_hs = 1'b0;

  function automatic grant_t predict_grant(request_t rq);
    grant_t      g;
    int unsigned cls;
    int unsigned idx;
    int unsigned k;
    g.status = ST_OK;
    g.addr   = '0;
    g.cls    = '0;
    g.bytes  = '0;
    g.reused = 1'b0;
    if (rq.is_free == REQ_ALLOC) begin
      if (rq.size == 0) begin
        g.status = ST_ZERO;
      end else if (rq.size > CLASS_BYTES[NUM_CLASSES-1]) begin
        g.status = ST_TOO_LARGE;
      end else begin
        cls = 0;
        for (k = NUM_CLASSES; k > 0; k--) begin
          if (CLASS_BYTES[k-1] >= rq.size) cls = k - 1;
        end
        if (list_len[cls] != 0) begin
          idx = list_head[cls];
          list_head[cls] = link_of[idx];
          list_len[cls]--;
          block_live[idx] = 1'b1;
          block_tag[idx] = 4'(cls);
          g.addr   = 20'(idx * MIN_BLOCK);
          g.cls    = 4'(cls);
          g.bytes  = CLASS_BYTES[cls];
          g.reused = 1'b1;
          live_blocks.push_back(idx * MIN_BLOCK);
        end else if (bump_ptr + CLASS_BYTES[cls] > HEAP_BYTES) begin
          g.status = ST_NO_MEM;
          g.cls    = 4'(cls);
        end else begin
          idx = 32'(bump_ptr / MIN_BLOCK);
          block_live[idx] = 1'b1;
          block_tag[idx] = 4'(cls);
          g.addr  = 20'(bump_ptr);
          g.cls   = 4'(cls);
          g.bytes = CLASS_BYTES[cls];
          live_blocks.push_back(32'(bump_ptr));
          bump_ptr += CLASS_BYTES[cls];
        end
      end
    end else begin
      idx = rq.addr / MIN_BLOCK;
      if (rq.addr >= HEAP_BYTES || (rq.addr % MIN_BLOCK) != 0 || !block_live[idx]) begin
        g.status = ST_BAD_FREE;
      end else begin
        cls = block_tag[idx];
        block_live[idx] = 1'b0;
        link_of[idx] = list_head[cls];
        list_head[cls] = idx;
        list_len[cls]++;
        g.cls   = 4'(cls);
        g.bytes = CLASS_BYTES[cls];
        for (k = 0; k < live_blocks.size(); k++) begin
          if (live_blocks[k] == rq.addr) begin
            live_blocks.delete(k);
            break;
          end
        end
        freed_blocks.push_back(rq.addr);
        if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
      end
    end
    return g;
  endfunction

  // Ignored field of each request carries random bits.
  task automatic push_req(input bit kind, input int unsigned size, input int unsigned addr);
    request_t    rq;
    logic [31:0] r1;
    logic [31:0] r2;
    r1 = $urandom();
    r2 = $urandom();
    rq.is_free = kind;
    rq.size = (kind == REQ_FREE) ? r1[25:0] : size[25:0];
    rq.addr = (kind == REQ_ALLOC) ? r2[19:0] : addr[19:0];
    req_q.push_back(rq);
    items_pushed++;
  endtask

  task automatic push_random_req();
    int unsigned pick;
    int unsigned sel;
    int unsigned cls;
    int unsigned lo;
    int unsigned hi;
    int unsigned size;
    int unsigned addr;
    logic [31:0] r;
    pick = $urandom_range(0, 99);
    r = $urandom();
    if (pick < 55) begin
      if (pick < 2) begin
        size = 0;
      end else if (pick < 5) begin
        size = $urandom_range(CLASS_BYTES[NUM_CLASSES-1] + 1, MAX_SIZE);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 70)      cls = $urandom_range(0, 5);
        else if (sel < 88) cls = $urandom_range(6, 8);
        else if (sel < 96) cls = $urandom_range(9, 11);
        else               cls = $urandom_range(12, 15);
        lo = (cls == 0) ? 1 : CLASS_BYTES[cls-1] + 1;
        hi = CLASS_BYTES[cls];
        case ($urandom_range(0, 3))
          0: size = hi;
          1: size = lo;
          default: size = $urandom_range(lo, hi);
        endcase
      end
      push_req(REQ_ALLOC, size, 0);
    end else begin
      if (pick < 85 && live_blocks.size() > 0) begin
        addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      end else if (pick < 90) begin
        addr = (r & 32'h000F_FFF8) | $urandom_range(1, MIN_BLOCK - 1);  // misaligned
      end else if (pick < 95 && freed_blocks.size() > 0) begin
        addr = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];  // likely double
      end else begin
        addr = r & 32'h000F_FFF8;
      end
      push_req(REQ_FREE, 0, addr);
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sender: bursts of random length, each followed by a random gap that may be empty
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  always @(negedge clk_i) begin
    request_t rq;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !s_hs)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (req_q.size() > 0) begin
        rq = req_q.pop_front();
        s_axis_tdata  <= {2'b00, rq.addr, rq.size};
        s_axis_tuser  <= rq.is_free;
        s_axis_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches among always, half and quarter ready modes, plus one long hold
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(16, 96);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: predict on request transactions, check on result transactions
  always @(posedge clk_i) begin
    request_t rq;
    grant_t   exp;
    s_hs = rst_ni && s_axis_tvalid && s_axis_tready;
    if (s_hs) begin
      rq.is_free = s_axis_tuser;
      rq.size    = s_axis_tdata[25:0];
      rq.addr    = s_axis_tdata[45:26];
      grant_q.push_back(predict_grant(rq));
      items_taken++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result status=%0d data=%h", m_axis_tuser, m_axis_tdata);
      end else begin
        exp = grant_q.pop_front();
        if (m_axis_tuser !== exp.status || m_axis_tdata[19:0] !== exp.addr ||
            m_axis_tdata[23:20] !== exp.cls || m_axis_tdata[49:24] !== exp.bytes ||
            m_axis_tdata[50] !== exp.reused) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"ERROR: result %0d exp st=%0d addr=%h cls=%0d bytes=%0d ",
                      "reused=%0d, got st=%0d addr=%h cls=%0d bytes=%0d reused=%0d"},
                     results_seen, exp.status, exp.addr, exp.cls, exp.bytes, exp.reused,
                     m_axis_tuser, m_axis_tdata[19:0], m_axis_tdata[23:20],
                     m_axis_tdata[49:24], m_axis_tdata[50]);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_segregated_free_list_allocator_top failed");
    $finish;
  end

  initial begin
    int unsigned n;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // rejections before anything is carved
    push_req(REQ_ALLOC, 0, 0);
    push_req(REQ_ALLOC, CLASS_BYTES[NUM_CLASSES-1] + 1, 0);
    push_req(REQ_ALLOC, MAX_SIZE, 0);
    push_req(REQ_ALLOC, CLASS_BYTES[NUM_CLASSES-1], 0);
    push_req(REQ_ALLOC, 1048577, 0);
    // fresh blocks on and just past class boundaries
    push_req(REQ_ALLOC, 1, 0);
    push_req(REQ_ALLOC, 8, 0);
    push_req(REQ_ALLOC, 9, 0);
    push_req(REQ_ALLOC, 32, 0);
    push_req(REQ_ALLOC, 33, 0);
    // good free, double free, misaligned, interior, unallocated
    push_req(REQ_FREE, 0, 8);
    push_req(REQ_FREE, 0, 8);
    push_req(REQ_FREE, 0, 3);
    push_req(REQ_FREE, 0, 24);
    push_req(REQ_FREE, 0, 1048575);
    push_req(REQ_FREE, 0, 1048568);
    // LIFO reuse
    push_req(REQ_ALLOC, 5, 0);
    push_req(REQ_FREE, 0, 0);
    push_req(REQ_FREE, 0, 16);
    push_req(REQ_ALLOC, 2, 0);
    push_req(REQ_ALLOC, 20, 0);
    // big fresh block, then classes that no longer fit
    push_req(REQ_ALLOC, 524288, 0);
    push_req(REQ_ALLOC, 1048576, 0);
    push_req(REQ_ALLOC, 262145, 0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      while (req_q.size() >= 4) @(negedge clk_i);
      if (n == PAUSE_AT) begin
        while (items_taken != items_pushed || grant_q.size() != 0) @(negedge clk_i);
      end
      push_random_req();
    end

    while (items_taken != items_pushed || grant_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("tb_segregated_free_list_allocator_top passed");
    end else begin
      $display("tb_segregated_free_list_allocator_top failed");
    end
    $finish;
  end

endmodule
